// ===== sv/bwsd_pkg.sv =====
package bwsd_pkg;

   localparam int HISTORY_LEN = 9;
   localparam int PATTERN_W   = 9;
   localparam int TIME_W      = 32;

   typedef logic [HISTORY_LEN-1:0] hist_type;
   typedef logic [PATTERN_W-1:0]   pattern_type;

   typedef enum logic [1:0] {
      DET_NONE   = 2'd0,
      DET_START  = 2'd1,
      DET_LETTER = 2'd2,
      DET_STOP   = 2'd3
   } det_type;

   typedef enum logic {
      CSR_START_STOP = 1'b0,
      CSR_SYMBOL     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic    width_is_short;
      det_type detection;
      logic    reading_mode;
      logic    event_ignored;
   } result_type;

   // zero extend or truncate a pattern to the history length
   function automatic hist_type fit_pattern(input pattern_type p);
      hist_type r;
      r = '0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         if (i < PATTERN_W) begin
            r[i] = p[i];
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/bwsd_step.sv =====
module bwsd_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic [bwsd_pkg::TIME_W-1:0]      timestamp_ms,
   input  logic                             both_edges,
   input  bwsd_pkg::pattern_type            start_stop_pattern,
   input  bwsd_pkg::pattern_type            symbol_pattern,
   output bwsd_pkg::result_type             result
);
   import bwsd_pkg::*;

   logic [TIME_W-1:0] last_edge_ff, last_edge_in;
   logic [TIME_W-1:0] prev_width_ff, prev_width_in;
   logic              short_ff, short_in;
   hist_type          hist_ff, hist_in;
   logic              reading_ff, reading_in;

   logic [TIME_W-1:0] width;
   logic [TIME_W:0]   old_x2;
   logic [TIME_W:0]   new_x2;
   logic              cls;
   hist_type          shifted;
   logic              ss_hit;
   logic              sym_hit;
   det_type           det;

   always_comb begin
      width   = timestamp_ms - last_edge_ff;
      old_x2  = {prev_width_ff, 1'b0};
      new_x2  = {width, 1'b0};
      if ({1'b0, prev_width_ff} > new_x2) begin
         cls = 1'b1;
      end else if (old_x2 < {1'b0, width}) begin
         cls = 1'b0;
      end else begin
         cls = short_ff;
      end
      shifted = {hist_ff[HISTORY_LEN-2:0], cls};
      ss_hit  = (shifted == fit_pattern(start_stop_pattern));
      sym_hit = (shifted == fit_pattern(symbol_pattern));

      det        = DET_NONE;
      hist_in    = shifted;
      reading_in = reading_ff;
      if (!reading_ff) begin
         if (ss_hit) begin
            det        = DET_START;
            hist_in    = '0;
            reading_in = 1'b1;
         end
      end else begin
         if (sym_hit) begin
            det     = DET_LETTER;
            hist_in = '0;
         end else if (ss_hit) begin
            det        = DET_STOP;
            hist_in    = '0;
            reading_in = 1'b0;
         end
      end
      last_edge_in  = timestamp_ms;
      prev_width_in = width;
      short_in      = cls;

      if (both_edges) begin
         result.width_is_short = short_ff;
         result.detection      = DET_NONE;
         result.reading_mode   = reading_ff;
         result.event_ignored  = 1'b1;
      end else begin
         result.width_is_short = cls;
         result.detection      = det;
         result.reading_mode   = reading_in;
         result.event_ignored  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff  <= '0;
         prev_width_ff <= '0;
         short_ff      <= 1'b0;
         hist_ff       <= '0;
         reading_ff    <= 1'b0;
      end else if (enable && !both_edges) begin
         last_edge_ff  <= last_edge_in;
         prev_width_ff <= prev_width_in;
         short_ff      <= short_in;
         hist_ff       <= hist_in;
         reading_ff    <= reading_in;
      end
   end

endmodule

// ===== sv/bar_width_symbol_detector.sv =====
// Bar width symbol detector.
// Request channel (req_valid / req_stall): one word per sensor edge, carrying
// the edge time in ms and a flag for rise and fall seen together.
// Response channel (rsp_valid / rsp_stall): one word per request word, with
// the class of the measured bar, the detection code (start, letter, stop),
// the reading mode after the edge and an ignored flag.
// Registers (csr_write_enable, csr_index, csr_write_data): 0 is the start/stop
// pattern, 1 the letter pattern, oldest class in bit 8; write only when idle.
// A word that is taken is registered in the input stage, processed as it moves
// into the response register once that register is free, and offered on the
// response port from there.
// Throughput: one word per cycle unless the receiver stalls; the input
// register and the response register form a two-stage pipeline, and the edge
// state is updated as each non-ignored word leaves the input register.
// Reset clears the edge state, class history and reading mode, restores the
// default patterns and empties both stages.
// When the receiver stalls, the response holds; the input stage fills and
// then req_stall rises in the same cycle until the response is taken.
module bar_width_symbol_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bwsd_pkg::TIME_W-1:0]   req_timestamp_ms,
   input  logic                          req_both_edges,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_width_is_short,
   output logic [1:0]                    rsp_detection,
   output logic                          rsp_reading_mode,
   output logic                          rsp_event_ignored,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [bwsd_pkg::PATTERN_W-1:0] csr_write_data
);
   import bwsd_pkg::*;

   pattern_type       ss_pat_ff;
   pattern_type       sym_pat_ff;

   logic              in_valid_ff, in_valid_in;
   logic [TIME_W-1:0] in_ts_ff;
   logic              in_both_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        step_result;

   logic              out_ready;
   logic              advance;
   logic              take;

   always_comb begin
      out_ready    = !out_valid_ff || !rsp_stall;
      advance      = in_valid_ff && out_ready;
      req_stall    = in_valid_ff && !out_ready;
      take         = req_valid && !req_stall;
      in_valid_in  = take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ss_pat_ff  <= PATTERN_W'(363);
         sym_pat_ff <= PATTERN_W'(246);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_START_STOP: ss_pat_ff  <= csr_write_data;
            CSR_SYMBOL:     sym_pat_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ts_ff   <= req_timestamp_ms;
         in_both_ff <= req_both_edges;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   bwsd_step u_step (
      .clock              (clock),
      .reset              (reset),
      .enable             (advance),
      .timestamp_ms       (in_ts_ff),
      .both_edges         (in_both_ff),
      .start_stop_pattern (ss_pat_ff),
      .symbol_pattern     (sym_pat_ff),
      .result             (step_result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_width_is_short = out_ff.width_is_short;
   assign rsp_detection      = out_ff.detection;
   assign rsp_reading_mode   = out_ff.reading_mode;
   assign rsp_event_ignored  = out_ff.event_ignored;

   a_start_reads: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.detection == DET_START) |-> out_ff.reading_mode)
      else $error("start detected without entering reading mode");

   a_stop_idles: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.detection == DET_STOP) |-> !out_ff.reading_mode)
      else $error("stop detected while staying in reading mode");

   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.event_ignored |-> (out_ff.detection == DET_NONE))
      else $error("ignored word reports a detection");

   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("response appeared without a word in the input stage");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bwsd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned EDGES_PER_PHASE = 130;

   typedef struct {
      logic [TIME_W-1:0] ts;
      logic              both;
      int unsigned       gap;
   } sensor_word_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [TIME_W-1:0]    req_timestamp_ms = '0;
   logic                 req_both_edges = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_width_is_short;
   logic [1:0]           rsp_detection;
   logic                 rsp_reading_mode;
   logic                 rsp_event_ignored;
   logic                 csr_write_enable = 1'b0;
   logic                 csr_index = 1'b0;
   logic [PATTERN_W-1:0] csr_write_data = '0;

   bar_width_symbol_detector dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_timestamp_ms   (req_timestamp_ms),
      .req_both_edges     (req_both_edges),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_width_is_short (rsp_width_is_short),
      .rsp_detection      (rsp_detection),
      .rsp_reading_mode   (rsp_reading_mode),
      .rsp_event_ignored  (rsp_event_ignored),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   sensor_word_type pending_words[$];
   result_type      expected_results[$];

   logic            req_fire = 1'b0;
   logic            rsp_fire = 1'b0;
   int unsigned     tx_wait = 0;
   int unsigned     stall_left = 0;
   bit              tx_idle_on = 1'b1;
   bit              rx_idle_on = 1'b1;
   sensor_word_type next_word;

   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;
   int unsigned  words_checked = 0;
   int unsigned  ignored_seen = 0;
   int unsigned  det_seen[4] = '{0, 0, 0, 0};
   int unsigned  settings_run = 1;

   // bar state as the detector should hold it
   logic [TIME_W-1:0] bar_last_time;
   logic [TIME_W-1:0] bar_prev_width;
   logic              bar_short;
   hist_type          bar_history;
   logic              bar_reading;
   pattern_type       ss_pattern;
   pattern_type       letter_pattern;

   // stimulus side: mirror of the edge timing, used to shape bar classes
   logic [TIME_W-1:0] gen_time = '0;
   logic [TIME_W-1:0] gen_prev = '0;
   logic              gen_short = 1'b0;
   pattern_type       cfg_start_stop = 9'd363;
   pattern_type       cfg_symbol = 9'd246;
   int unsigned       edges_made = 0;

   function automatic logic next_class(logic [TIME_W-1:0] prev_w, logic [TIME_W-1:0] cur_w,
                                       logic cls);
      logic [TIME_W:0] prev_x;
      logic [TIME_W:0] cur_x;
      prev_x = {1'b0, prev_w};
      cur_x  = {1'b0, cur_w};
      if (prev_x > (cur_x << 1)) return 1'b1;
      if ((prev_x << 1) < cur_x) return 1'b0;
      return cls;
   endfunction

   function automatic result_type decode_edge(logic [TIME_W-1:0] ts, logic both);
      result_type       r;
      logic [TIME_W-1:0] w;
      r.event_ignored = both;
      r.detection     = DET_NONE;
      if (!both) begin
         w              = ts - bar_last_time;
         bar_short      = next_class(bar_prev_width, w, bar_short);
         bar_prev_width = w;
         bar_last_time  = ts;
         bar_history    = {bar_history[HISTORY_LEN-2:0], bar_short};
         if (!bar_reading) begin
            if (bar_history == hist_type'(ss_pattern)) begin
               r.detection = DET_START;
               bar_reading = 1'b1;
            end
         end else if (bar_history == hist_type'(letter_pattern)) begin
            r.detection = DET_LETTER;
         end else if (bar_history == hist_type'(ss_pattern)) begin
            r.detection = DET_STOP;
            bar_reading = 1'b0;
         end
         if (r.detection != DET_NONE) bar_history = '0;
      end
      r.width_is_short = bar_short;
      r.reading_mode   = bar_reading;
      return r;
   endfunction

   // monitor: results checked, register writes and accepted words predicted
   always @(posedge clock) begin
      if (reset) begin
         req_fire       <= 1'b0;
         rsp_fire       <= 1'b0;
         bar_last_time  = '0;
         bar_prev_width = '0;
         bar_short      = 1'b0;
         bar_history    = '0;
         bar_reading    = 1'b0;
         ss_pattern     = 9'd363;
         letter_pattern = 9'd246;
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response word with no request word outstanding");
               mismatches++;
            end else begin
               result_type want;
               want = expected_results.pop_front();
               words_checked++;
               if (want.event_ignored) ignored_seen++;
               det_seen[want.detection]++;
               if (rsp_width_is_short !== want.width_is_short) begin
                  $error("width_is_short: expected %0d, got %0d",
                         want.width_is_short, rsp_width_is_short);
                  mismatches++;
               end
               if (rsp_detection !== want.detection) begin
                  $error("detection: expected %0d, got %0d", want.detection, rsp_detection);
                  mismatches++;
               end
               if (rsp_reading_mode !== want.reading_mode) begin
                  $error("reading_mode: expected %0d, got %0d",
                         want.reading_mode, rsp_reading_mode);
                  mismatches++;
               end
               if (rsp_event_ignored !== want.event_ignored) begin
                  $error("event_ignored: expected %0d, got %0d",
                         want.event_ignored, rsp_event_ignored);
                  mismatches++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_START_STOP: ss_pattern = csr_write_data;
               CSR_SYMBOL:     letter_pattern = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(decode_edge(req_timestamp_ms, req_both_edges));
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (tx_wait < pending_words[0].gap) begin
            tx_wait++;
            req_valid <= 1'b0;
         end else begin
            next_word = pending_words.pop_front();
            tx_wait = 0;
            req_timestamp_ms <= next_word.ts;
            req_both_edges   <= next_word.both;
            req_valid        <= 1'b1;
         end
      end
   end

   // response stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_fire) stall_left = rx_idle_on ? $urandom_range(7, 0) : 0;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, expected_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [TIME_W-1:0] bar_width_for(logic want_short);
      longint unsigned p;
      longint unsigned lo;
      longint unsigned hi;
      p = gen_prev;
      if (p == 0) begin
         if (want_short) return '0;
         return $urandom_range(300, 20);
      end
      if (want_short == gen_short) begin
         lo = (p + 1) / 2;
         hi = 2 * p;
      end else if (want_short) begin
         lo = p / 4;
         hi = (p - 1) / 2;
      end else begin
         lo = 2 * p + 1;
         hi = 3 * p + 2;
      end
      if (hi > 64'h0000_0000_FFFF_FFFF) hi = 64'h0000_0000_FFFF_FFFF;
      if (lo > hi) lo = hi;
      return $urandom_range(hi[31:0], lo[31:0]);
   endfunction

   task automatic push_word(logic [TIME_W-1:0] ts, logic both);
      sensor_word_type w;
      w.ts   = ts;
      w.both = both;
      w.gap  = tx_idle_on ? $urandom_range(7, 0) : 0;
      pending_words.push_back(w);
      if (!both) begin
         gen_short = next_class(gen_prev, ts - gen_time, gen_short);
         gen_prev  = ts - gen_time;
         gen_time  = ts;
         edges_made++;
      end
   endtask

   task automatic push_bar(logic want_short);
      if ($urandom_range(9, 0) == 0) push_word($urandom, 1'b1);
      push_word(gen_time + bar_width_for(want_short), 1'b0);
   endtask

   task automatic push_pattern(pattern_type p);
      for (int i = PATTERN_W - 1; i >= 0; i--) push_bar(p[i]);
   endtask

   // one scan: settle the width scale, start code, zero to three symbols, stop code
   task automatic queue_scan();
      pattern_type opening;
      opening = cfg_start_stop;
      if ($urandom_range(5, 0) == 0) opening ^= pattern_type'(1) << $urandom_range(8, 0);
      push_word(gen_time, 1'b0);
      push_word(gen_time + $urandom_range(300, 20), 1'b0);
      push_pattern(opening);
      repeat ($urandom_range(3, 0)) begin
         if ($urandom_range(1, 0)) push_pattern(cfg_symbol);
         else push_pattern(pattern_type'($urandom));
      end
      push_pattern(cfg_start_stop);
   endtask

   task automatic queue_phase(int unsigned n_edges);
      int unsigned stop_at;
      stop_at = edges_made + n_edges;
      while (edges_made < stop_at) begin
         if ($urandom_range(9, 0) < 8) begin
            queue_scan();
         end else begin
            repeat ($urandom_range(4, 1)) push_word($urandom, $urandom_range(3, 0) == 0);
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic write_pattern(csr_index_type idx, pattern_type val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_START_STOP) cfg_start_stop = val;
      else cfg_symbol = val;
   endtask

   initial begin
      pattern_type shared;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first event with zero width, extremes of the time and the wrap
      push_word(32'h0000_0000, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b1);
      push_word(32'h0000_0064, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'h0000_000F, 1'b0);
      push_word(32'h0000_000F, 1'b1);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'h7FFF_FFFF, 1'b1);
      queue_phase(EDGES_PER_PHASE);

      for (int k = 1; k <= 5; k++) begin
         wait_drained();
         repeat (4) @(negedge clock);
         case (k)
            1: begin
               write_pattern(CSR_START_STOP, 9'h000);
               write_pattern(CSR_SYMBOL, 9'h1FF);
            end
            2: begin
               write_pattern(CSR_START_STOP, 9'h1FF);
               write_pattern(CSR_SYMBOL, 9'h000);
            end
            3: begin
               // letter and start/stop codes identical
               shared = pattern_type'($urandom);
               write_pattern(CSR_START_STOP, shared);
               write_pattern(CSR_SYMBOL, shared);
            end
            4: begin
               write_pattern(CSR_START_STOP, pattern_type'($urandom));
               write_pattern(CSR_SYMBOL, pattern_type'($urandom));
            end
            default: begin
               write_pattern(CSR_START_STOP, 9'd363);
               write_pattern(CSR_SYMBOL, 9'd246);
               tx_idle_on = 1'b0;
               rx_idle_on = 1'b0;
            end
         endcase
         settings_run++;
         @(posedge clock);
         queue_phase(EDGES_PER_PHASE);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("checked %0d words (%0d with both edges) under %0d pattern settings",
               words_checked, ignored_seen, settings_run);
      $display("decoded %0d start codes, %0d letters, %0d stop codes",
               det_seen[DET_START], det_seen[DET_LETTER], det_seen[DET_STOP]);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/bwsd_pkg.sv
sv/bwsd_step.sv
sv/bar_width_symbol_detector.sv
tb/sv/tb_top.sv
